FILE: src/jsl_pkg.sv
// Shared types, codes and reset values for the jet selection block.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package jsl_pkg;

  // Default capacity of the lepton table, one chain cell per lepton.
  localparam int MAX_LEPTONS_DEF = 16;

  // Field widths fixed by the item format.
  localparam int PT_W    = 14;
  localparam int ETA_W   = 11;
  localparam int PHI_W   = 10;
  localparam int ELIM_W  = 10;
  localparam int DR2_W   = 20;
  localparam int CADDR_W = 3;
  localparam int CDATA_W = 20;

  // Width of a squared distance: an 11-bit square plus a 10-bit square.
  localparam int DIST_W  = 2 * ETA_W + 1;

  typedef enum logic [1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_CLASSIFY = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    VERDICT_KEPT       = 3'd0,
    VERDICT_KINEMATICS = 3'd1,
    VERDICT_QUALITY    = 3'd2,
    VERDICT_PILEUP     = 3'd3,
    VERDICT_OVERLAP    = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    ID_LOOSE       = 2'd0,
    ID_TIGHT       = 2'd1,
    ID_TIGHT_LEPVETO = 2'd2
  } id_mode_t;

  typedef enum logic [CADDR_W-1:0] {
    REG_PT_MIN          = 3'd0,
    REG_PT_MAX          = 3'd1,
    REG_ETA_LIMIT       = 3'd2,
    REG_ID_MODE         = 3'd3,
    REG_PILEUP_REQUIRED = 3'd4,
    REG_OVERLAP_ENABLE  = 3'd5,
    REG_DR2_LIMIT       = 3'd6
  } reg_addr_t;

  // Register reset values.
  localparam logic [PT_W-1:0]   PT_MIN_RST    = 14'd80;
  localparam logic [PT_W-1:0]   PT_MAX_RST    = 14'd16383;
  localparam logic [ELIM_W-1:0] ETA_LIMIT_RST = 10'd408;
  localparam logic [1:0]        ID_MODE_RST   = ID_LOOSE;
  localparam logic              PILEUP_RST    = 1'b1;
  localparam logic              OVERLAP_RST   = 1'b1;
  localparam logic [DR2_W-1:0]  DR2_LIMIT_RST = 20'd4250;

  // A jet as it travels down the chain of lepton cells.
  typedef struct packed {
    logic                    valid;
    logic signed [ETA_W-1:0] eta;
    logic [PHI_W-1:0]        phi;
    verdict_t                pre;
    logic                    hit;
  } jet_t;

endpackage

`default_nettype wire

FILE: src/jsl_if.sv
// Valid/ready channel interfaces for jet items, verdicts and register writes.
// Depends on jsl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface jsl_in_if;
  import jsl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [PT_W-1:0]         pt;
  logic signed [ETA_W-1:0] eta;
  logic [PHI_W-1:0]        phi;
  logic                    loose_id;
  logic                    tight_id;
  logic                    tight_lepveto_id;
  logic                    pileup_loose;

  modport source (output valid, action, pt, eta, phi, loose_id, tight_id,
                  tight_lepveto_id, pileup_loose, input ready);
  modport sink   (input valid, action, pt, eta, phi, loose_id, tight_id,
                  tight_lepveto_id, pileup_loose, output ready);
endinterface

interface jsl_out_if;
  logic       valid;
  logic       ready;
  logic       keep;
  logic [2:0] verdict;
  logic       lepton_overflow;

  modport source (output valid, keep, verdict, lepton_overflow, input ready);
  modport sink   (input valid, keep, verdict, lepton_overflow, output ready);
endinterface

interface jsl_cfg_if;
  import jsl_pkg::*;
  logic               valid;
  logic               ready;
  logic [CADDR_W-1:0] addr;
  logic [CDATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

FILE: src/jsl_cell.sv
// One lepton cell: holds one stored lepton and checks a passing jet against it.
// Depends on jsl_pkg for the jet record and field widths.
`timescale 1ns / 1ps
`default_nettype none

module jsl_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             advance,
  input  wire logic                             occupied,
  input  wire logic [jsl_pkg::DR2_W-1:0]        dr2_limit,
  input  wire logic                             wr_en,
  input  wire logic signed [jsl_pkg::ETA_W-1:0] wr_eta,
  input  wire logic [jsl_pkg::PHI_W-1:0]        wr_phi,
  input  wire jsl_pkg::jet_t                    jet_i,
  output jsl_pkg::jet_t                         jet_o
);
  import jsl_pkg::*;

  logic signed [ETA_W-1:0] lep_eta_r;
  logic [PHI_W-1:0]        lep_phi_r;
  jet_t                    jet_r;
  jet_t                    jet_nxt;

  logic signed [ETA_W:0]   deta;
  logic [ETA_W-1:0]        adeta;
  logic [PHI_W-1:0]        dphi_raw;
  logic [PHI_W:0]          dphi_wide;
  logic [PHI_W-1:0]        dphi;
  logic [2*ETA_W-1:0]      eta_sq;
  logic [2*PHI_W-1:0]      phi_sq;
  logic [DIST_W-1:0]       dist2;
  logic                    close;

  // Stored lepton; written when the table pointer selects this cell.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lep_eta_r <= wr_eta;
      lep_phi_r <= wr_phi;
    end
  end

  // Squared angular distance between the passing jet and the stored lepton.
  // The phi difference takes the shorter way round the circle.
  always_comb begin
    deta      = {jet_i.eta[ETA_W-1], jet_i.eta} - {lep_eta_r[ETA_W-1], lep_eta_r};
    adeta     = deta[ETA_W] ? ETA_W'(-deta) : deta[ETA_W-1:0];
    dphi_raw  = jet_i.phi - lep_phi_r;
    dphi_wide = (PHI_W+1)'(1 << PHI_W) - {1'b0, dphi_raw};
    dphi      = (dphi_raw > PHI_W'(1 << (PHI_W - 1))) ? dphi_wide[PHI_W-1:0] : dphi_raw;
    eta_sq    = adeta * adeta;
    phi_sq    = dphi * dphi;
    dist2     = {1'b0, eta_sq} + {{(DIST_W - 2*PHI_W){1'b0}}, phi_sq};
    close     = occupied && (dist2 < {{(DIST_W - DR2_W){1'b0}}, dr2_limit});
    jet_nxt     = jet_i;
    jet_nxt.hit = jet_i.hit | close;
  end

  // Hand the jet to the next cell whenever the chain moves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jet_r.valid <= 1'b0;
    end else if (advance) begin
      jet_r.valid <= jet_nxt.valid;
    end
    if (advance) begin
      jet_r.eta <= jet_nxt.eta;
      jet_r.phi <= jet_nxt.phi;
      jet_r.pre <= jet_nxt.pre;
      jet_r.hit <= jet_nxt.hit;
    end
  end

  assign jet_o = jet_r;

endmodule

`default_nettype wire

FILE: src/jet_select_lepton_overlap.sv
// Top level of the jet selection block with lepton overlap removal.
// Depends on jsl_pkg, the channel interfaces in jsl_if and jsl_cell.
`timescale 1ns / 1ps
`default_nettype none

// Items arrive on in_ch. A clear or an add lepton item gives no result. A
// classify item runs through a chain of MAX_LEPTONS cells, one cell per cycle
// while the chain is not stalled, each cell holding one stored lepton, and its
// verdict then goes into the output register; the input is held off until that
// happens and then takes the next item at once, even while the verdict still
// waits on out_ch. Leptons beyond MAX_LEPTONS are dropped and reported by
// lepton_overflow until the next clear. Register writes on cfg_ch are always
// taken and should only be made while no jet is in flight.
module jet_select_lepton_overlap #(
  parameter int MAX_LEPTONS = jsl_pkg::MAX_LEPTONS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  jsl_in_if.sink     in_ch,
  jsl_out_if.source  out_ch,
  jsl_cfg_if.sink    cfg_ch
);
  import jsl_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEPTONS + 1);

  // Configuration registers.
  logic [PT_W-1:0]   pt_min_r;
  logic [PT_W-1:0]   pt_max_r;
  logic [ELIM_W-1:0] eta_limit_r;
  logic [1:0]        id_mode_r;
  logic              pileup_required_r;
  logic              overlap_enable_r;
  logic [DR2_W-1:0]  dr2_limit_r;

  // Table and flow control state.
  logic [CNT_W-1:0]  count_r;
  logic              overflow_r;
  logic              busy_r;
  logic              out_valid_r;
  logic              out_keep_r;
  verdict_t          out_verdict_r;
  logic              out_overflow_r;

  logic              in_xfer;
  logic              add_xfer;
  logic              advance;
  logic              chain_done;
  logic [ETA_W-1:0]  abs_eta;
  logic              id_ok;
  verdict_t          pre_verdict;
  verdict_t          final_verdict;
  jet_t              entry_jet;
  jet_t              chain [MAX_LEPTONS+1];
  logic [MAX_LEPTONS-1:0] occupied;
  logic [MAX_LEPTONS-1:0] wr_sel;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !busy_r;
  assign in_xfer      = in_ch.valid && !busy_r;
  assign add_xfer     = in_xfer && (in_ch.action == ACT_ADD);

  // Register writes; addresses past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_min_r          <= PT_MIN_RST;
      pt_max_r          <= PT_MAX_RST;
      eta_limit_r       <= ETA_LIMIT_RST;
      id_mode_r         <= ID_MODE_RST;
      pileup_required_r <= PILEUP_RST;
      overlap_enable_r  <= OVERLAP_RST;
      dr2_limit_r       <= DR2_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_PT_MIN:          pt_min_r          <= cfg_ch.data[PT_W-1:0];
        REG_PT_MAX:          pt_max_r          <= cfg_ch.data[PT_W-1:0];
        REG_ETA_LIMIT:       eta_limit_r       <= cfg_ch.data[ELIM_W-1:0];
        REG_ID_MODE:         id_mode_r         <= cfg_ch.data[1:0];
        REG_PILEUP_REQUIRED: pileup_required_r <= cfg_ch.data[0];
        REG_OVERLAP_ENABLE:  overlap_enable_r  <= cfg_ch.data[0];
        REG_DR2_LIMIT:       dr2_limit_r       <= cfg_ch.data[DR2_W-1:0];
        default: ;
      endcase
    end
  end

  // Lepton table pointer and overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (in_xfer) begin
      unique case (in_ch.action)
        ACT_CLEAR: begin
          count_r    <= '0;
          overflow_r <= 1'b0;
        end
        ACT_ADD: begin
          if (count_r < CNT_W'(MAX_LEPTONS)) begin
            count_r <= count_r + 1'b1;
          end else begin
            overflow_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Kinematic, quality and pileup checks, in that order, when a jet enters.
  always_comb begin
    abs_eta = in_ch.eta[ETA_W-1] ? ETA_W'(-in_ch.eta) : in_ch.eta;
    unique case (id_mode_r)
      ID_LOOSE:         id_ok = in_ch.loose_id;
      ID_TIGHT:         id_ok = in_ch.tight_id;
      ID_TIGHT_LEPVETO: id_ok = in_ch.tight_lepveto_id;
      default:          id_ok = 1'b0;
    endcase
    if (!(in_ch.pt >= pt_min_r && in_ch.pt < pt_max_r &&
          abs_eta < {1'b0, eta_limit_r})) begin
      pre_verdict = VERDICT_KINEMATICS;
    end else if (!id_ok) begin
      pre_verdict = VERDICT_QUALITY;
    end else if (pileup_required_r && !in_ch.pileup_loose) begin
      pre_verdict = VERDICT_PILEUP;
    end else begin
      pre_verdict = VERDICT_KEPT;
    end
  end

  // Entry of the chain.
  always_comb begin
    entry_jet.valid = in_xfer && (in_ch.action == ACT_CLASSIFY);
    entry_jet.eta   = in_ch.eta;
    entry_jet.phi   = in_ch.phi;
    entry_jet.pre   = pre_verdict;
    entry_jet.hit   = 1'b0;
  end

  assign chain[0] = entry_jet;

  // The chain stops only when a finished jet meets a full output register that out_ch is not taking.
  assign chain_done = chain[MAX_LEPTONS].valid;
  assign advance    = !(chain_done && out_valid_r && !out_ch.ready);

  // Row of lepton cells.
  for (genvar i = 0; i < MAX_LEPTONS; i++) begin : g_cell
    assign occupied[i] = CNT_W'(i) < count_r;
    assign wr_sel[i]   = add_xfer && (count_r == CNT_W'(i));

    jsl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .occupied  (occupied[i]),
      .dr2_limit (dr2_limit_r),
      .wr_en     (wr_sel[i]),
      .wr_eta    (in_ch.eta),
      .wr_phi    (in_ch.phi),
      .jet_i     (chain[i]),
      .jet_o     (chain[i+1])
    );
  end

  // The overlap verdict applies only when the earlier checks passed.
  always_comb begin
    if (chain[MAX_LEPTONS].pre != VERDICT_KEPT) begin
      final_verdict = chain[MAX_LEPTONS].pre;
    end else if (overlap_enable_r && chain[MAX_LEPTONS].hit) begin
      final_verdict = VERDICT_OVERLAP;
    end else begin
      final_verdict = VERDICT_KEPT;
    end
  end

  // Busy flag and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (chain[0].valid) begin
        busy_r <= 1'b1;
      end else if (chain_done && advance) begin
        busy_r <= 1'b0;
      end
      if (chain_done && advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (chain_done && advance) begin
      out_keep_r     <= (final_verdict == VERDICT_KEPT);
      out_verdict_r  <= final_verdict;
      out_overflow_r <= overflow_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.keep            = out_keep_r;
  assign out_ch.verdict         = out_verdict_r;
  assign out_ch.lepton_overflow = out_overflow_r;

endmodule

`default_nettype wire

FILE: src/jsl_checker.sv
// Port-level checks for the jet selection block, bound to its top level.
// Depends on jsl_pkg for the action and verdict codes.
`timescale 1ns / 1ps
`default_nettype none

module jsl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_action,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_keep,
  input wire logic [2:0] out_verdict,
  input wire logic       out_overflow
);
  import jsl_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_keep) && $stable(out_verdict) && $stable(out_overflow))
    else $error("result changed while stalled");

  // A jet occupies the cell chain, so the input closes right after it.
  a_jet_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_CLASSIFY) |=> !in_ready)
    else $error("input open while a jet is in the chain");

  // The keep bit agrees with the verdict.
  a_keep_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_keep == (out_verdict == VERDICT_KEPT)))
    else $error("keep disagrees with verdict");

endmodule

bind jet_select_lepton_overlap jsl_checker u_jsl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_action    (in_ch.action),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_keep     (out_ch.keep),
  .out_verdict  (out_ch.verdict),
  .out_overflow (out_ch.lepton_overflow)
);

`default_nettype wire
